@@ hw/rtl/assert_macros.svh @@
// Assertion helpers included by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

@@ hw/rtl/bir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bicubic resampler package
// Fixed widths, register indexes, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package bir_pkg;

	localparam int SW_W    = 9;   // source size register width
	localparam int DW_W    = 13;  // destination size register width
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 13;
	localparam int COORD_W = 12;
	localparam int CH_W    = 8;

	localparam int PROD_W  = 22;            // (2d+1)*src
	localparam int DEN_W   = 14;            // 2*dst
	localparam int DVD_W   = PROD_W + 16;   // dividend with 16 fraction bits
	localparam int BASE_W  = PROD_W + 1;    // signed integer position
	localparam int FR_W    = 16;
	localparam int P_W     = 53;            // cubic numerators
	localparam int WT_W    = 18;            // Q4.14 weight
	localparam int TW_W    = 2 * WT_W;      // Q8.28 tap weight
	localparam int PX_W    = CH_W + 1 + TW_W;
	localparam int ACC_W   = 50;
	localparam int RND_W   = ACC_W - 28;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [5:0] DIV_STEPS = 6'd38;
	localparam logic [4:0] TAP_LAST  = 5'd17;
	localparam logic [4:0] TAP_COUNT = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_SQR,
		ST_CUBE,
		ST_WGT,
		ST_TAPS,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/bicubic_image_resampler.sv @@
`timescale 1ns / 1ps
// A query runs from acceptance to its result word through one setup state, a 38-step
// bit-serial division for both axes, the weight states SQR, CUBE and WGT, sixteen reads
// of the single-port frame store plus the product pipeline, and a registered result. The
// input is stalled until the query is back in idle, so a new query waits for the last one
// and a stalled result holds the input; one load per cycle is taken while idle; loads return no word.
// Reset clears control state and configuration registers; datapath and frame store are not cleared.
// ----------------------------------------------------------------------------
// Bicubic image resampler
// Keys (a = -1/2) RGBA interpolation over a source frame store held in one RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bicubic_image_resampler #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int MAX_DST_SIZE   = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bir_pkg::CFG_DAT_W-1:0]  cfg_data,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [bir_pkg::COORD_W-1:0]    col,
	input  logic [bir_pkg::COORD_W-1:0]    row,
	input  logic [bir_pkg::CH_W-1:0]       red_in,
	input  logic [bir_pkg::CH_W-1:0]       green_in,
	input  logic [bir_pkg::CH_W-1:0]       blue_in,
	input  logic [bir_pkg::CH_W-1:0]       alpha_in,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bir_pkg::CH_W-1:0]       red_out,
	output logic [bir_pkg::CH_W-1:0]       green_out,
	output logic [bir_pkg::CH_W-1:0]       blue_out,
	output logic [bir_pkg::CH_W-1:0]       alpha_out
);

	localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back.
	// ------------------------------------------------------------------
	logic [bir_pkg::SW_W-1:0] src_width_q, src_height_q;
	logic [bir_pkg::DW_W-1:0] dst_width_q, dst_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bir_pkg::SW_W'(256);
			src_height_q <= bir_pkg::SW_W'(256);
			dst_width_q  <= bir_pkg::DW_W'(1024);
			dst_height_q <= bir_pkg::DW_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bir_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[bir_pkg::SW_W-1:0];
				bir_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[bir_pkg::SW_W-1:0];
				bir_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				bir_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Registers are saturated into their legal range where they are used:
	// zero behaves as one, anything above the maximum as the maximum.
	logic [bir_pkg::SW_W-1:0] sw, sh;
	logic [bir_pkg::DW_W-1:0] dw, dh;

	always_comb begin
		sw = src_width_q;
		if (src_width_q == '0) sw = bir_pkg::SW_W'(1);
		else if (int'(src_width_q) > MAX_SRC_WIDTH) sw = bir_pkg::SW_W'(MAX_SRC_WIDTH);
		sh = src_height_q;
		if (src_height_q == '0) sh = bir_pkg::SW_W'(1);
		else if (int'(src_height_q) > MAX_SRC_HEIGHT) sh = bir_pkg::SW_W'(MAX_SRC_HEIGHT);
		dw = dst_width_q;
		if (dst_width_q == '0) dw = bir_pkg::DW_W'(1);
		else if (int'(dst_width_q) > MAX_DST_SIZE) dw = bir_pkg::DW_W'(MAX_DST_SIZE);
		dh = dst_height_q;
		if (dst_height_q == '0) dh = bir_pkg::DW_W'(1);
		else if (int'(dst_height_q) > MAX_DST_SIZE) dh = bir_pkg::DW_W'(MAX_DST_SIZE);
	end

	// ------------------------------------------------------------------
	// Sequencer. In-range loads are written straight into the frame store in the
	// cycle they are accepted; queries walk through the states below.
	// ------------------------------------------------------------------
	bir_pkg::state_t state_q, state_d;

	logic in_acc;
	logic out_free;
	logic load_ok;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != bir_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_ok  = (int'(col) < MAX_SRC_WIDTH) && (int'(row) < MAX_SRC_HEIGHT);

	logic [5:0] div_cnt_q;
	logic [4:0] tap_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bir_pkg::ST_IDLE: begin
				if (in_acc && opcode == bir_pkg::OP_QUERY) state_d = bir_pkg::ST_SETUP;
			end
			bir_pkg::ST_SETUP: state_d = bir_pkg::ST_DIV;
			bir_pkg::ST_DIV: begin
				if (div_cnt_q == bir_pkg::DIV_STEPS - 6'd1) state_d = bir_pkg::ST_SQR;
			end
			bir_pkg::ST_SQR:  state_d = bir_pkg::ST_CUBE;
			bir_pkg::ST_CUBE: state_d = bir_pkg::ST_WGT;
			bir_pkg::ST_WGT:  state_d = bir_pkg::ST_TAPS;
			bir_pkg::ST_TAPS: begin
				if (tap_q == bir_pkg::TAP_LAST) state_d = bir_pkg::ST_DONE;
			end
			bir_pkg::ST_DONE: begin
				if (out_free) state_d = bir_pkg::ST_IDLE;
			end
			default: state_d = bir_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bir_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Position mapping. Each axis divides ((2d+1)*src - dst) * 2^16 by
	// 2*dst. A negative numerator is lifted by one denominator first and
	// the integer part is lowered by one afterwards, so the divider only
	// sees non-negative values. Both axes share the step counter.
	// ------------------------------------------------------------------
	logic [bir_pkg::COORD_W-1:0] qcol_q, qrow_q;
	logic [bir_pkg::DVD_W-1:0]   dvx_q, dvy_q;   // dividend, then quotient
	logic [bir_pkg::DEN_W-1:0]   rmx_q, rmy_q;
	logic [bir_pkg::DEN_W-1:0]   dnx_q, dny_q;
	logic                        negx_q, negy_q;

	logic [bir_pkg::PROD_W-1:0]   prx, pry;
	logic signed [bir_pkg::PROD_W:0] numx, numy;
	logic [bir_pkg::DEN_W-1:0]   denx, deny;
	logic [bir_pkg::PROD_W-1:0]   n2x, n2y;

	assign prx  = bir_pkg::PROD_W'({qcol_q, 1'b1} * sw);
	assign pry  = bir_pkg::PROD_W'({qrow_q, 1'b1} * sh);
	assign numx = $signed({1'b0, prx}) - $signed({{(bir_pkg::PROD_W - bir_pkg::DW_W + 1){1'b0}}, dw});
	assign numy = $signed({1'b0, pry}) - $signed({{(bir_pkg::PROD_W - bir_pkg::DW_W + 1){1'b0}}, dh});
	assign denx = {dw, 1'b0};
	assign deny = {dh, 1'b0};
	assign n2x  = numx[bir_pkg::PROD_W] ?
		bir_pkg::PROD_W'(numx + $signed({{(bir_pkg::PROD_W - bir_pkg::DEN_W + 1){1'b0}}, denx})) :
		numx[bir_pkg::PROD_W-1:0];
	assign n2y  = numy[bir_pkg::PROD_W] ?
		bir_pkg::PROD_W'(numy + $signed({{(bir_pkg::PROD_W - bir_pkg::DEN_W + 1){1'b0}}, deny})) :
		numy[bir_pkg::PROD_W-1:0];

	// One restoring step per cycle: shift a dividend bit into the partial
	// remainder and shift the quotient bit into the freed dividend slot.
	logic [bir_pkg::DEN_W:0] trx, try_;
	logic                    gex, gey;

	assign trx  = {rmx_q, dvx_q[bir_pkg::DVD_W-1]};
	assign try_ = {rmy_q, dvy_q[bir_pkg::DVD_W-1]};
	assign gex  = trx >= {1'b0, dnx_q};
	assign gey  = try_ >= {1'b0, dny_q};

	// Integer base and fraction from the quotient.
	logic [bir_pkg::FR_W-1:0]          fx, fy;
	logic signed [bir_pkg::BASE_W-1:0] bx, by;

	assign fx = dvx_q[bir_pkg::FR_W-1:0];
	assign fy = dvy_q[bir_pkg::FR_W-1:0];
	assign bx = $signed({1'b0, dvx_q[bir_pkg::DVD_W-1:bir_pkg::FR_W]})
		- $signed({{(bir_pkg::BASE_W-1){1'b0}}, negx_q});
	assign by = $signed({1'b0, dvy_q[bir_pkg::DVD_W-1:bir_pkg::FR_W]})
		- $signed({{(bir_pkg::BASE_W-1){1'b0}}, negy_q});

	// ------------------------------------------------------------------
	// Weights: t^2, then t^3, then the four Keys cubics per axis scaled by
	// 2*2^48 and rounded half up into Q4.14.
	// ------------------------------------------------------------------
	logic [2*bir_pkg::FR_W-1:0] f2x_q, f2y_q;
	logic [3*bir_pkg::FR_W-1:0] f3x_q, f3y_q;
	logic signed [bir_pkg::WT_W-1:0] wx_q [4];
	logic signed [bir_pkg::WT_W-1:0] wy_q [4];
	logic signed [bir_pkg::WT_W-1:0] wxn [4];
	logic signed [bir_pkg::WT_W-1:0] wyn [4];

	function automatic void keys_weights(
		input  logic [bir_pkg::FR_W-1:0]   f,
		input  logic [2*bir_pkg::FR_W-1:0] f2,
		input  logic [3*bir_pkg::FR_W-1:0] f3,
		output logic signed [bir_pkg::WT_W-1:0] w0,
		output logic signed [bir_pkg::WT_W-1:0] w1,
		output logic signed [bir_pkg::WT_W-1:0] w2,
		output logic signed [bir_pkg::WT_W-1:0] w3
	);
		logic signed [bir_pkg::P_W-1:0] t3, t2s, ts2, s3, rnd;
		logic signed [bir_pkg::P_W-1:0] p0, p1, p2, p3;
		t3  = $signed(bir_pkg::P_W'(f3));
		t2s = $signed(bir_pkg::P_W'({f2, 16'd0}));
		ts2 = $signed(bir_pkg::P_W'({f, 32'd0}));
		s3  = $signed(bir_pkg::P_W'(1) <<< 48);
		rnd = $signed(bir_pkg::P_W'(1) <<< 34);
		p0 = -t3 + (t2s <<< 1) - ts2;
		p1 = t3 + (t3 <<< 1) - ((t2s <<< 2) + t2s) + (s3 <<< 1);
		p2 = -(t3 + (t3 <<< 1)) + (t2s <<< 2) + ts2;
		p3 = t3 - t2s;
		w0 = bir_pkg::WT_W'((p0 + rnd) >>> 35);
		w1 = bir_pkg::WT_W'((p1 + rnd) >>> 35);
		w2 = bir_pkg::WT_W'((p2 + rnd) >>> 35);
		w3 = bir_pkg::WT_W'((p3 + rnd) >>> 35);
	endfunction

	always_comb begin
		keys_weights(fx, f2x_q, f3x_q, wxn[0], wxn[1], wxn[2], wxn[3]);
		keys_weights(fy, f2y_q, f3y_q, wyn[0], wyn[1], wyn[2], wyn[3]);
	end

	// ------------------------------------------------------------------
	// Tap walk. Tap k reads row m = k/4 and column n = k%4 of the clamped
	// neighborhood. Stage 1 forms the tap weight while the RAM reads,
	// stage 2 multiplies each channel, and the accumulators add stage 2.
	// ------------------------------------------------------------------
	logic [1:0] tm, tn;
	logic signed [bir_pkg::BASE_W:0] cyr, cxr;
	logic [bir_pkg::SW_W-1:0] cy, cx;
	logic issue;

	assign tm    = tap_q[3:2];
	assign tn    = tap_q[1:0];
	assign issue = (state_q == bir_pkg::ST_TAPS) && (tap_q < bir_pkg::TAP_COUNT);
	assign cyr   = by - $signed((bir_pkg::BASE_W+1)'(1)) + $signed({{(bir_pkg::BASE_W-1){1'b0}}, tm});
	assign cxr   = bx - $signed((bir_pkg::BASE_W+1)'(1)) + $signed({{(bir_pkg::BASE_W-1){1'b0}}, tn});

	always_comb begin
		if (cyr < 0) cy = '0;
		else if (cyr > $signed({{(bir_pkg::BASE_W-bir_pkg::SW_W+1){1'b0}}, sh - 9'd1}))
			cy = sh - 9'd1;
		else cy = cyr[bir_pkg::SW_W-1:0];
		if (cxr < 0) cx = '0;
		else if (cxr > $signed({{(bir_pkg::BASE_W-bir_pkg::SW_W+1){1'b0}}, sw - 9'd1}))
			cx = sw - 9'd1;
		else cx = cxr[bir_pkg::SW_W-1:0];
	end

	// ------------------------------------------------------------------
	// Frame store: one word per pixel, red in the low byte, alpha on top.
	// ------------------------------------------------------------------
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [31:0]       ram_wdata, ram_rdata;

	assign ram_we    = in_acc && opcode == bir_pkg::OP_LOAD && load_ok;
	assign ram_wdata = {alpha_in, blue_in, green_in, red_in};
	assign ram_addr  = (state_q == bir_pkg::ST_IDLE) ?
		ADDR_W'(int'(row) * MAX_SRC_WIDTH + int'(col)) :
		ADDR_W'(int'(cy) * MAX_SRC_WIDTH + int'(cx));

	bir_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic                             v_s1, v_s2;
	logic signed [bir_pkg::TW_W-1:0]  tw_s1;
	logic signed [bir_pkg::PX_W-1:0]  prod_s2 [4];
	logic signed [bir_pkg::ACC_W-1:0] acc_q [4];
	logic [bir_pkg::CH_W-1:0]         res [4];

	// Rounding half up and clamping to a byte.
	always_comb begin
		logic signed [bir_pkg::RND_W-1:0] v;
		for (int c = 0; c < 4; c++) begin
			v = bir_pkg::RND_W'((acc_q[c] + $signed(bir_pkg::ACC_W'(1) <<< 27)) >>> 28);
			if (v < 0) res[c] = '0;
			else if (v > $signed(bir_pkg::RND_W'(255))) res[c] = 8'd255;
			else res[c] = v[bir_pkg::CH_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Control counters and pipeline valids.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			tap_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == bir_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 6'd1;
			else div_cnt_q <= '0;
			if (state_q == bir_pkg::ST_TAPS) tap_q <= tap_q + 5'd1;
			else tap_q <= '0;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == bir_pkg::ST_DONE && out_free) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			qcol_q <= col;
			qrow_q <= row;
		end
		case (state_q)
			bir_pkg::ST_SETUP: begin
				dvx_q  <= {n2x, 16'd0};
				dvy_q  <= {n2y, 16'd0};
				rmx_q  <= '0;
				rmy_q  <= '0;
				dnx_q  <= denx;
				dny_q  <= deny;
				negx_q <= numx[bir_pkg::PROD_W];
				negy_q <= numy[bir_pkg::PROD_W];
				for (int c = 0; c < 4; c++) acc_q[c] <= '0;
			end
			bir_pkg::ST_DIV: begin
				rmx_q <= gex ? bir_pkg::DEN_W'(trx - {1'b0, dnx_q}) : trx[bir_pkg::DEN_W-1:0];
				rmy_q <= gey ? bir_pkg::DEN_W'(try_ - {1'b0, dny_q}) : try_[bir_pkg::DEN_W-1:0];
				dvx_q <= {dvx_q[bir_pkg::DVD_W-2:0], gex};
				dvy_q <= {dvy_q[bir_pkg::DVD_W-2:0], gey};
			end
			bir_pkg::ST_SQR: begin
				f2x_q <= fx * fx;
				f2y_q <= fy * fy;
			end
			bir_pkg::ST_CUBE: begin
				f3x_q <= f2x_q * fx;
				f3y_q <= f2y_q * fy;
			end
			bir_pkg::ST_WGT: begin
				for (int k = 0; k < 4; k++) begin
					wx_q[k] <= wxn[k];
					wy_q[k] <= wyn[k];
				end
			end
			default: ;
		endcase
		if (issue) tw_s1 <= wy_q[tm] * wx_q[tn];
		if (v_s1) begin
			for (int c = 0; c < 4; c++)
				prod_s2[c] <= $signed({1'b0, ram_rdata[8*c +: 8]}) * tw_s1;
		end
		if (v_s2) begin
			for (int c = 0; c < 4; c++)
				acc_q[c] <= acc_q[c] + bir_pkg::ACC_W'(prod_s2[c]);
		end
		if (state_q == bir_pkg::ST_DONE && out_free) begin
			red_out   <= res[0];
			green_out <= res[1];
			blue_out  <= res[2];
			alpha_out <= res[3];
		end
	end

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`ASSERT_CLK(a_load_only_idle, clk, arst_n,
		ram_we |-> state_q == bir_pkg::ST_IDLE, "frame store written outside idle")
	`ASSERT_NEVER(a_tap_range, clk, arst_n,
		state_q == bir_pkg::ST_TAPS && tap_q > bir_pkg::TAP_LAST, "tap counter overran")
	`ASSERT_CLK(a_done_emits, clk, arst_n,
		(state_q == bir_pkg::ST_DONE && out_free) |=> (out_valid && state_q == bir_pkg::ST_IDLE),
		"finished query did not reach the output register")
	`ASSERT_NEVER(a_pipe_after_taps, clk, arst_n,
		state_q == bir_pkg::ST_DONE && (v_s1 || v_s2), "tap pipeline busy after walk")

endmodule

@@ hw/rtl/bir_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
